FILE: design/uetrb_pkg.sv
// -----------------------------------------------------------------------------
// uetrb_pkg
// Shared types, constants and the digit word table for the echo transmit ring.
// -----------------------------------------------------------------------------
package uetrb_pkg;

	// Default ring depth
	localparam int RING_DEPTH_DEF = 64;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int FILL_W   = 7;
	localparam int DROP_W   = 3;
	localparam int IDX_W    = 3;
	localparam int DIGIT_W  = 4;
	localparam int WORD_MAX = 5;

	// Output beat packing: tx_byte, fill_level, dropped, then zero fill to bytes
	localparam int OUT_FIELDS_W = BYTE_W + FILL_W + DROP_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	// Input kinds
	localparam logic KIND_RX_BYTE  = 1'b0;
	localparam logic KIND_TX_READY = 1'b1;

	// ASCII digit range
	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_PUSH,
		SEQ_POP,
		SEQ_RESULT
	} seq_state_t;

	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic [FILL_W-1:0] fill_level;
		logic [DROP_W-1:0] dropped;
	} result_t;

	// Index of the last character of a digit's word (length minus one)
	function automatic logic [IDX_W-1:0] word_last(input logic [DIGIT_W-1:0] digit);
		logic [IDX_W-1:0] last;
		case (digit)
			4'd0:    last = 3'd3;
			4'd1:    last = 3'd2;
			4'd2:    last = 3'd2;
			4'd3:    last = 3'd4;
			4'd4:    last = 3'd3;
			4'd5:    last = 3'd3;
			4'd6:    last = 3'd2;
			4'd7:    last = 3'd4;
			4'd8:    last = 3'd4;
			4'd9:    last = 3'd3;
			default: last = 3'd0;
		endcase
		return last;
	endfunction

	// Character at position idx of a digit's English word
	function automatic logic [BYTE_W-1:0] word_char(input logic [DIGIT_W-1:0] digit,
	                                                input logic [IDX_W-1:0] idx);
		logic [WORD_MAX*BYTE_W-1:0] w;
		logic [BYTE_W-1:0]          c;
		case (digit)
			4'd0:    w = {"zero", 8'h00};
			4'd1:    w = {"one", 16'h0000};
			4'd2:    w = {"two", 16'h0000};
			4'd3:    w = "three";
			4'd4:    w = {"four", 8'h00};
			4'd5:    w = {"five", 8'h00};
			4'd6:    w = {"six", 16'h0000};
			4'd7:    w = "seven";
			4'd8:    w = "eight";
			4'd9:    w = {"nine", 8'h00};
			default: w = '0;
		endcase
		case (idx)
			3'd0:    c = w[5*BYTE_W-1 -: BYTE_W];
			3'd1:    c = w[4*BYTE_W-1 -: BYTE_W];
			3'd2:    c = w[3*BYTE_W-1 -: BYTE_W];
			3'd3:    c = w[2*BYTE_W-1 -: BYTE_W];
			3'd4:    c = w[1*BYTE_W-1 -: BYTE_W];
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: design/uart_echo_tx_ring_buffer_core.sv
// -----------------------------------------------------------------------------
// uart_echo_tx_ring_buffer_core
// Echo transmit queue: received bytes are pushed into a byte ring, digits
// expanded to their English word, and transmitter-ready beats pop the oldest.
//
//   channel | dir | tdata                      | tuser
//   s_*     | in  | [7:0] rx_byte              | kind (0 rx byte, 1 tx ready)
//   m_*     | out | [7:0] tx_byte, [14:8]      | tx_valid
//           |     | fill_level, [17:15] dropped|
//
// A received byte is accepted, then N bytes are offered to the ring (1, or 3
// to 5 for a digit word, dropped bytes included), at one ring write per cycle,
// and then its result is handed off.
// A pop is accepted with a ring read, its read data is captured and the result
// is handed off; a ready beat on an empty ring is accepted and then handed off.
// Reset clears positions and fill count; the ring contents need no clearing.
// A stalled m_* beat is held in the output register; one more item may be
// worked on meanwhile, and the sequencer waits only to hand off its result.
// -----------------------------------------------------------------------------
module uart_echo_tx_ring_buffer_core #(
	parameter int RING_DEPTH = uetrb_pkg::RING_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [uetrb_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
	input  logic                              s_tuser,   // [0] kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [uetrb_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] tx_byte, [14:8] fill_level,
	                                                     // [17:15] dropped, [23:18] zero
	output logic                              m_tuser    // [0] tx_valid
);
	import uetrb_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_ready;
	result_t           res;

	// Ring storage
	uetrb_ring_mem #(
		.RING_DEPTH(RING_DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Item sequencer
	uetrb_seq #(
		.RING_DEPTH(RING_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.in_byte  (s_tdata),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output beat register
	uetrb_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: design/uetrb_ring_mem.sv
// -----------------------------------------------------------------------------
// uetrb_ring_mem
// Byte ring storage: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module uetrb_ring_mem #(
	parameter int RING_DEPTH = uetrb_pkg::RING_DEPTH_DEF,
	localparam int AW        = $clog2(RING_DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [uetrb_pkg::BYTE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [uetrb_pkg::BYTE_W-1:0] rdata
);
	import uetrb_pkg::*;

	logic [BYTE_W-1:0] mem [RING_DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	// Write on push, read on pop; the read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/uetrb_seq.sv
// -----------------------------------------------------------------------------
// uetrb_seq
// Item sequencer: expands digits to words, pushes bytes one per cycle, pops
// through the ring memory and tracks the write/read positions and fill count.
// -----------------------------------------------------------------------------
module uetrb_seq #(
	parameter int RING_DEPTH = uetrb_pkg::RING_DEPTH_DEF,
	localparam int AW        = $clog2(RING_DEPTH),
	localparam int CW        = $clog2(RING_DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input beat
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_kind,
	input  logic [uetrb_pkg::BYTE_W-1:0] in_byte,
	// ring memory port
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [uetrb_pkg::BYTE_W-1:0] mem_wdata,
	output logic                         mem_re,
	output logic [AW-1:0]                mem_raddr,
	input  logic [uetrb_pkg::BYTE_W-1:0] mem_rdata,
	// result hand-off
	output logic                         res_valid,
	input  logic                         res_ready,
	output uetrb_pkg::result_t           res
);
	import uetrb_pkg::*;

	seq_state_t state_q, state_d;

	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [CW-1:0]      fill_q;
	logic [DROP_W-1:0]  drop_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   last_q;
	logic               res_tx_q;
	logic [BYTE_W-1:0]  rx_q;
	logic [DIGIT_W-1:0] digit_q;
	logic               is_word_q;
	logic [BYTE_W-1:0]  res_byte_q;

	logic                   accept;
	logic                   in_is_digit;
	logic                   ring_empty;
	logic                   ring_room;
	logic                   push_step;
	logic                   pop_start;
	logic [BYTE_W-1:0]      push_byte;
	logic [CW+FILL_W-1:0]   fill_ext;

	// Decode the incoming beat and the ring status
	assign in_is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
	assign ring_empty  = (fill_q == '0);
	assign ring_room   = (fill_q != CW'(RING_DEPTH));
	assign push_byte   = is_word_q ? word_char(digit_q, idx_q) : rx_q;
	assign fill_ext    = {{FILL_W{1'b0}}, fill_q};

	// Pushes only run in SEQ_PUSH and reads only start from SEQ_IDLE, so the
	// two ports never touch the ring in the same cycle
	assign mem_waddr = wr_ptr_q;
	assign mem_wdata = push_byte;
	assign mem_raddr = rd_ptr_q;

	assign res.tx_valid   = res_tx_q;
	assign res.tx_byte    = res_byte_q;
	assign res.fill_level = fill_ext[FILL_W-1:0];
	assign res.dropped    = drop_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		push_step = 1'b0;
		pop_start = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (in_valid) begin
					if (in_kind == KIND_RX_BYTE) begin
						state_d = SEQ_PUSH;
					end else if (!ring_empty) begin
						pop_start = 1'b1;
						mem_re    = 1'b1;
						state_d   = SEQ_POP;
					end else begin
						state_d = SEQ_RESULT;
					end
				end
			end
			SEQ_PUSH: begin
				push_step = 1'b1;
				mem_we    = ring_room;
				if (idx_q == last_q) begin
					state_d = SEQ_RESULT;
				end
			end
			SEQ_POP: begin
				state_d = SEQ_RESULT;
			end
			SEQ_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// Positions, fill count, word index and drop count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			drop_q   <= '0;
			idx_q    <= '0;
			last_q   <= '0;
			res_tx_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q    <= '0;
				drop_q   <= '0;
				last_q   <= in_is_digit ? word_last(in_byte[DIGIT_W-1:0]) : '0;
				res_tx_q <= pop_start;
			end
			if (push_step) begin
				idx_q <= idx_q + 1'b1;
				if (ring_room) begin
					wr_ptr_q <= (wr_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
					fill_q   <= fill_q + 1'b1;
				end else begin
					drop_q <= drop_q + 1'b1;
				end
			end
			if (pop_start) begin
				rd_ptr_q <= (rd_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				fill_q   <= fill_q - 1'b1;
			end
		end
	end

	// Hold the beat payload and capture the popped byte
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_q       <= in_byte;
			digit_q    <= in_byte[DIGIT_W-1:0];
			is_word_q  <= in_is_digit;
			res_byte_q <= '0;
		end
		if (state_q == SEQ_POP) begin
			res_byte_q <= mem_rdata;
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_pop_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_POP) |-> $past(mem_re))
		else $error("pop state without a ring read");

	a_drop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q <= DROP_W'(WORD_MAX))
		else $error("drop count beyond a word length");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(push_step && !ring_room) |=> (fill_q == CW'(RING_DEPTH)) && $stable(wr_ptr_q))
		else $error("write position moved on a full ring");
`endif

endmodule

FILE: design/uetrb_out_stage.sv
// -----------------------------------------------------------------------------
// uetrb_out_stage
// Output register: holds one result beat so the sequencer can take the next
// item while the beat waits on the master side.
// -----------------------------------------------------------------------------
module uetrb_out_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               res_valid,
	output logic                               res_ready,
	input  uetrb_pkg::result_t                 res,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [uetrb_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                               m_tuser
);
	import uetrb_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign res_ready = !valid_q || m_tready;

	// Load a new beat when empty or when the held one drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.tx_valid;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_q.dropped, res_q.fill_level, res_q.tx_byte};

endmodule

FILE: tb/echo_ring_checker.sv
// -----------------------------------------------------------------------------
// echo_ring_checker
// Watches both stream channels of the echo transmit ring. It keeps its own
// copy of the byte ring, works out the result of every accepted input beat and
// compares each output beat, field by field, with the oldest one still awaited.
// -----------------------------------------------------------------------------
module echo_ring_checker #(
	parameter int RING_DEPTH = uetrb_pkg::RING_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [uetrb_pkg::BYTE_W-1:0]      s_tdata,
	input  logic                              s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [uetrb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                              m_tuser,
	output int                                errors,
	output int                                outstanding
);
	import uetrb_pkg::*;

	logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
	int unsigned       head;
	int unsigned       level;
	result_t           awaited_results [$];
	result_t           want;
	result_t           next_result;
	int                mismatch_cnt;

	// English word that replaces a received digit
	function automatic string digit_word(input logic [DIGIT_W-1:0] digit);
		string w;
		case (digit)
			4'd0:    w = "zero";
			4'd1:    w = "one";
			4'd2:    w = "two";
			4'd3:    w = "three";
			4'd4:    w = "four";
			4'd5:    w = "five";
			4'd6:    w = "six";
			4'd7:    w = "seven";
			4'd8:    w = "eight";
			4'd9:    w = "nine";
			default: w = "";
		endcase
		return w;
	endfunction

	// Store one byte if there is room, otherwise count it as lost
	task automatic push_byte(input logic [BYTE_W-1:0] b, inout int unsigned lost);
		if (level >= RING_DEPTH) begin
			lost++;
		end else begin
			ring_bytes[head] = b;
			head = (head + 1) % RING_DEPTH;
			level++;
		end
	endtask

	// Apply one input beat to the ring copy and build the result it causes
	task automatic advance_ring(input logic kind, input logic [BYTE_W-1:0] rx,
	                            output result_t r);
		string       w;
		int unsigned lost;
		int unsigned rd;
		r = '0;
		lost = 0;
		if (kind == KIND_RX_BYTE) begin
			if (rx >= CHAR_ZERO && rx <= CHAR_NINE) begin
				w = digit_word(DIGIT_W'(rx - CHAR_ZERO));
				for (int i = 0; i < w.len(); i++)
					push_byte(w[i], lost);
			end else begin
				push_byte(rx, lost);
			end
		end else if (level > 0) begin
			rd = (head + RING_DEPTH - level) % RING_DEPTH;
			r.tx_valid = 1'b1;
			r.tx_byte  = ring_bytes[rd];
			level--;
		end
		r.fill_level = level[FILL_W-1:0];
		r.dropped    = lost[DROP_W-1:0];
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
			         $time, name, exp_val, exp_val, act_val, act_val);
			mismatch_cnt++;
		end
	endtask

	// Check output beats first, then predict from input beats of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			level = 0;
			awaited_results.delete();
			mismatch_cnt = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result beat with nothing awaited, expected none, got tdata=0x%0h tuser=%0b",
					         $time, m_tdata, m_tuser);
					mismatch_cnt++;
				end else begin
					want = awaited_results.pop_front();
					check_field("tx_valid", want.tx_valid, m_tuser);
					check_field("tx_byte", want.tx_byte, m_tdata[BYTE_W-1:0]);
					check_field("fill_level", want.fill_level,
					            m_tdata[BYTE_W+FILL_W-1:BYTE_W]);
					check_field("dropped", want.dropped,
					            m_tdata[OUT_FIELDS_W-1:BYTE_W+FILL_W]);
					check_field("tdata pad", 0, m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]);
				end
			end
			if (s_tvalid && s_tready) begin
				advance_ring(s_tuser, s_tdata, next_result);
				awaited_results.push_back(next_result);
			end
			errors <= mismatch_cnt;
			outstanding <= awaited_results.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Regression for the echo transmit ring: a directed opening (extreme bytes,
// non-digit neighbors of the digit range, every digit word, pops on an empty
// and a full ring, partial and total drops), then random beats in phases that
// fill, drain or mix the ring, with random gaps on both channels, one long
// receiver hold that backs up the input and drain pauses on the sender side.
// -----------------------------------------------------------------------------
module testbench;
	import uetrb_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	int                     fail_total;
	int                     pending;
	int                     beats_taken;
	bit                     sender_burst;

	uart_echo_tx_ring_buffer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	echo_ring_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.errors      (fail_total),
		.outstanding (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop in case a beat never arrives
	initial begin
		#2000000;
		$display("uart_echo_tx_ring_buffer_core regression: fail");
		$finish;
	end

	// Result side: random stalls, one long hold, and a stretch with no stalls
	initial begin
		int gap;
		m_tready = 1'b0;
		beats_taken = 0;
		@(posedge arst_n);
		forever begin
			if (beats_taken == 150)
				gap = 400;
			else if (beats_taken >= 500 && beats_taken < 600)
				gap = 0;
			else
				gap = $urandom_range(0, 10);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			beats_taken++;
		end
	end

	// Offer one beat after a random gap (none in a sender burst) and hold it until accepted
	task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering until every awaited result has come back
	task automatic drain_ring;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int                pop_pct;
		logic              kind;
		logic [BYTE_W-1:0] b;
		s_tvalid = 1'b0;
		s_tuser = KIND_RX_BYTE;
		s_tdata = '0;
		sender_burst = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, extreme bytes, digit-range neighbors, all words
		send_item(KIND_TX_READY, BYTE_W'($urandom_range(0, 255)));
		send_item(KIND_RX_BYTE, 8'h00);
		send_item(KIND_RX_BYTE, 8'hFF);
		send_item(KIND_RX_BYTE, CHAR_ZERO - 8'd1);
		send_item(KIND_RX_BYTE, CHAR_NINE + 8'd1);
		for (int d = 0; d < 10; d++)
			send_item(KIND_RX_BYTE, CHAR_ZERO + BYTE_W'(d));
		repeat (3) send_item(KIND_TX_READY, BYTE_W'($urandom_range(0, 255)));
		// Overfill with five-letter words: one partial drop, then a whole-word drop
		repeat (6) send_item(KIND_RX_BYTE, CHAR_ZERO + 8'd7);
		// Pop from the full ring
		send_item(KIND_TX_READY, BYTE_W'($urandom_range(0, 255)));
		drain_ring();

		// Random phases that lean toward filling, draining or a mix
		for (int blk = 0; blk < 15; blk++) begin
			case ($urandom_range(0, 2))
				0:       pop_pct = 10;
				1:       pop_pct = 50;
				default: pop_pct = 90;
			endcase
			sender_burst = ($urandom_range(0, 3) == 0);
			if (blk >= 4 && (blk == 5 || $urandom_range(0, 2) == 0))
				drain_ring();
			repeat (60) begin
				kind = ($urandom_range(0, 99) < pop_pct) ? KIND_TX_READY : KIND_RX_BYTE;
				if ($urandom_range(0, 99) < 40)
					b = CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
				else
					b = BYTE_W'($urandom_range(0, 255));
				send_item(kind, b);
			end
		end
		sender_burst = 1'b0;
		drain_ring();
		repeat (20) @(posedge clk);

		if (fail_total == 0)
			$display("uart_echo_tx_ring_buffer_core regression: pass");
		else
			$display("uart_echo_tx_ring_buffer_core regression: fail");
		$finish;
	end

endmodule
